// ===== hdl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants for the record sort-by-date block.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int MAX_RECORDS_DEF = 64;

    localparam int ID_W    = 27;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        S_LOAD,
        S_NEXT,
        S_HELD,
        S_CMP,
        S_PLACE,
        S_EMIT_LD,
        S_EMIT_OUT
    } state_t;

    function automatic logic [KEY_W-1:0] date_key(input rec_t r);
        return {r.year, r.month, r.day};
    endfunction

endpackage

// ===== hdl/rsd_store.sv =====
// ----------------------------------------------------------------------------
// rsd_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsd_store #(
    parameter int DEPTH = rsd_pkg::MAX_RECORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  rsd_pkg::rec_t wdata,
    input  logic [AW-1:0] raddr,
    output rsd_pkg::rec_t rdata
);
    import rsd_pkg::*;

    rec_t mem [DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rsd_key_cmp.sv =====
// ----------------------------------------------------------------------------
// rsd_key_cmp
// Date compare unit: high when record a sorts strictly after record b.
// ----------------------------------------------------------------------------
module rsd_key_cmp (
    input  rsd_pkg::rec_t a,
    input  rsd_pkg::rec_t b,
    output logic          a_after_b
);
    import rsd_pkg::*;

    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;

    assign key_a     = date_key(a);
    assign key_b     = date_key(b);
    assign a_after_b = key_a > key_b;

endmodule

// ===== hdl/rsd_seq.sv =====
// ----------------------------------------------------------------------------
// rsd_seq
// Sequencer: loads records, runs the insertion sort over the store through
// the compare unit, then streams the sorted words out.
// ----------------------------------------------------------------------------
module rsd_seq #(
    parameter int MAX_RECORDS = rsd_pkg::MAX_RECORDS_DEF,
    parameter int AW          = $clog2(MAX_RECORDS),
    parameter int CW          = $clog2(MAX_RECORDS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rec_valid,
    output logic                      rec_stall,
    input  logic [rsd_pkg::ID_W-1:0]    record_id,
    input  logic [rsd_pkg::DAY_W-1:0]   birth_day,
    input  logic [rsd_pkg::MONTH_W-1:0] birth_month,
    input  logic [rsd_pkg::YEAR_W-1:0]  birth_year,
    input  logic                      last_record,
    output logic                      out_valid,
    input  logic                      out_stall,
    output rsd_pkg::rec_t             out_rec,
    output logic                      out_last,
    output logic                      records_dropped,
    output logic                      mem_we,
    output logic [AW-1:0]             mem_waddr,
    output rsd_pkg::rec_t             mem_wdata,
    output logic [AW-1:0]             mem_raddr,
    input  rsd_pkg::rec_t             mem_rdata,
    output rsd_pkg::rec_t             cmp_a,
    output rsd_pkg::rec_t             cmp_b,
    input  logic                      cmp_gt
);
    import rsd_pkg::*;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] k_reg, k_next;
    rec_t          held_reg, held_next;
    rec_t          out_rec_reg, out_rec_next;
    logic          out_last_reg, out_last_next;
    logic          out_drop_reg, out_drop_next;
    rec_t          in_rec;

    assign in_rec = '{id: record_id, year: birth_year, month: birth_month, day: birth_day};

    assign cmp_a = mem_rdata;
    assign cmp_b = held_reg;

    assign rec_stall       = state_reg != S_LOAD;
    assign out_valid       = state_reg == S_EMIT_OUT;
    assign out_rec         = out_rec_reg;
    assign out_last        = out_last_reg;
    assign records_dropped = out_drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            pos_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            pos_reg   <= pos_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg     <= held_next;
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        held_next     = held_reg;
        out_rec_next  = out_rec_reg;
        out_last_next = out_last_reg;
        out_drop_next = out_drop_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = held_reg;
        mem_raddr     = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (rec_valid)
                begin
                    if (count_reg < CW'(MAX_RECORDS))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = in_rec;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_record)
                    begin
                        i_next     = CW'(1);
                        state_next = S_NEXT;
                    end
                end
            end
            S_NEXT:
            begin
                if (i_reg == count_reg)
                begin
                    mem_raddr  = '0;
                    k_next     = '0;
                    state_next = S_EMIT_LD;
                end
                else
                begin
                    mem_raddr  = i_reg[AW-1:0];
                    state_next = S_HELD;
                end
            end
            S_HELD:
            begin
                held_next  = mem_rdata;
                pos_next   = i_reg[AW-1:0];
                mem_raddr  = i_reg[AW-1:0] - AW'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                if (cmp_gt)
                begin
                    mem_wdata = mem_rdata;
                    pos_next  = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        mem_raddr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    mem_wdata  = held_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_NEXT;
                end
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = held_reg;
                i_next     = i_reg + CW'(1);
                state_next = S_NEXT;
            end
            S_EMIT_LD:
            begin
                out_rec_next  = mem_rdata;
                out_last_next = (CW'(k_reg) + CW'(1)) == count_reg;
                out_drop_next = ovf_reg;
                state_next    = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (!out_stall)
                begin
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        mem_raddr  = k_reg + AW'(1);
                        state_next = S_EMIT_LD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RECORDS))
        else $error("record count above capacity");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !rec_stall |-> !out_valid)
        else $error("loading while a sorted word is pending");

    a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && !rec_stall && last_record) |=> rec_stall)
        else $error("last record did not start the sort");

    a_pos_below_i: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (CW'(pos_reg) <= i_reg && pos_reg != '0))
        else $error("insert position out of range");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_last) |=> (count_reg == '0 && !ovf_reg))
        else $error("batch state not cleared after final word");
`endif

endmodule

// ===== hdl/record_sort_by_date_top.sv =====
// ----------------------------------------------------------------------------
// record_sort_by_date_top
// Batch sorter: stores dated records, stable insertion sort by date, emits.
// ----------------------------------------------------------------------------
// Load: one record word per cycle until the word marked last.
// Sort: each record after the first is held, then compared with earlier ones in turn,
//   later-dated ones moving up a slot; the single port pair and compare unit serialise it.
// Emit: sorted words go out one by one, held under back-pressure; input stalls meanwhile.
// Reset clears the sequencer, record count and overflow flag; store untouched.
module record_sort_by_date_top #(
    parameter int MAX_RECORDS = rsd_pkg::MAX_RECORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rec_valid,
    output logic                        rec_stall,
    input  logic [rsd_pkg::ID_W-1:0]    record_id,
    input  logic [rsd_pkg::DAY_W-1:0]   birth_day,
    input  logic [rsd_pkg::MONTH_W-1:0] birth_month,
    input  logic [rsd_pkg::YEAR_W-1:0]  birth_year,
    input  logic                        last_record,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rsd_pkg::ID_W-1:0]    out_id,
    output logic [rsd_pkg::DAY_W-1:0]   out_day,
    output logic [rsd_pkg::MONTH_W-1:0] out_month,
    output logic [rsd_pkg::YEAR_W-1:0]  out_year,
    output logic                        out_last,
    output logic                        records_dropped
);
    import rsd_pkg::*;

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    rec_t          mem_wdata;
    rec_t          mem_rdata;
    rec_t          cmp_a;
    rec_t          cmp_b;
    logic          cmp_gt;
    rec_t          out_rec;

    rsd_store #(
        .DEPTH (MAX_RECORDS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rsd_key_cmp u_cmp (
        .a         (cmp_a),
        .b         (cmp_b),
        .a_after_b (cmp_gt)
    );

    rsd_seq #(
        .MAX_RECORDS (MAX_RECORDS),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .rec_valid       (rec_valid),
        .rec_stall       (rec_stall),
        .record_id       (record_id),
        .birth_day       (birth_day),
        .birth_month     (birth_month),
        .birth_year      (birth_year),
        .last_record     (last_record),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_rec         (out_rec),
        .out_last        (out_last),
        .records_dropped (records_dropped),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata),
        .cmp_a           (cmp_a),
        .cmp_b           (cmp_b),
        .cmp_gt          (cmp_gt)
    );

    assign out_id    = out_rec.id;
    assign out_day   = out_rec.day;
    assign out_month = out_rec.month;
    assign out_year  = out_rec.year;

endmodule
